[rtl/core/kgst_pkg.sv]
`timescale 1ns / 1ps

package kgst_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // register indexes of the write port
   localparam logic CSR_TRANSLATION = 1'b0;
   localparam logic CSR_ROTATION    = 1'b1;

   typedef struct packed {
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
      logic signed [15:0] pose_heading;
      logic signed [31:0] local_x;
      logic signed [31:0] local_y;
      logic               first_of_scan;
      logic               pose_only;
   } req_type;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_y;
      logic        [31:0] point_number;
      logic        [31:0] keyframe_number;
   } rsp_type;

   // one point of an accepted scan, with the pose it is placed by
   typedef struct packed {
      logic signed [31:0] local_x;
      logic signed [31:0] local_y;
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
      logic        [15:0] heading;
      logic        [31:0] keyframe_count;
   } entry_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_SQUARE,
      FR_DECIDE
   } fr_state_type;

   // sine of a 32 bit turn fraction, odd taylor series in q30, rounded to frac bits
   function automatic logic signed [31:0] phase_sine(input logic [31:0] p, input int frac);
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      logic [63:0] prod;
      logic [1:0]  quad;
      quad = p[31:30];
      r = {34'd0, p[29:0]};
      if (quad[0]) begin
         r = Q30_ONE - r;
      end
      x = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t = Q30_ONE;
      for (int i = 0; i < 6; i++) begin
         prod = (x2 * t) >> 30;
         case (i)
            0: prod = prod / 64'd156;
            1: prod = prod / 64'd110;
            2: prod = prod / 64'd72;
            3: prod = prod / 64'd42;
            4: prod = prod / 64'd20;
            default: prod = prod / 64'd6;
         endcase
         t = Q30_ONE - prod;
      end
      s = (x * t) >> 30;
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      v = (s + (64'd1 << (29 - frac))) >> (30 - frac);
      return quad[1] ? (32'd0 - v[31:0]) : v[31:0];
   endfunction

   // clamp a 36 bit signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (!v[35] && (v[34:31] != 4'h0)) begin
         r = 32'h7FFF_FFFF;
      end else if (v[35] && (v[34:31] != 4'hF)) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[rtl/core/kgst_queue.sv]
`timescale 1ns / 1ps

module kgst_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  kgst_pkg::entry_type push_entry,
   input  logic                pop,
   output kgst_pkg::entry_type head_entry,
   output logic                empty,
   output logic                full
);

   localparam int PW = $clog2(kgst_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(kgst_pkg::QUEUE_DEPTH + 1);

   kgst_pkg::entry_type slot_ff [kgst_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign empty = (count_ff == CW'(0));
   assign full = (count_ff == CW'(kgst_pkg::QUEUE_DEPTH));
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(kgst_pkg::QUEUE_DEPTH - 1)) ? PW'(0) : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(kgst_pkg::QUEUE_DEPTH - 1)) ? PW'(0) : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/kgst_front.sv]
`timescale 1ns / 1ps

module kgst_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  kgst_pkg::req_type   req_data,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [30:0]         csr_wdata,
   input  logic                queue_full,
   output logic                push,
   output kgst_pkg::entry_type push_entry
);

   kgst_pkg::fr_state_type state_ff, state_in;

   logic [30:0] trans_thr_ff;
   logic [15:0] rot_thr_ff;

   logic               have_kf_ff;
   logic               scan_acc_ff;
   logic signed [31:0] last_x_ff;
   logic signed [31:0] last_y_ff;
   logic [15:0]        last_h_ff;
   logic [31:0]        kf_count_ff;

   logic signed [31:0] pend_x_ff, pend_y_ff, pend_lx_ff, pend_ly_ff;
   logic [15:0]        pend_h_ff;
   logic               pend_pose_only_ff;
   logic [30:0]        adx_ff, ady_ff;
   logic               far_ff;
   logic               near_rot_ff;
   logic [61:0]        sq_x_ff, sq_y_ff, thr_sq_ff;

   logic               accept;
   logic signed [32:0] dx, dy;
   logic [32:0]        adx, ady;
   logic [15:0]        dh;
   logic [16:0]        adh;
   logic               near_pos;
   logic               gate_accept;
   logic [31:0]        kf_next;

   assign accept = req_valid && !req_stall;
   assign kf_next = (kf_count_ff == 32'hFFFF_FFFF) ? kf_count_ff : kf_count_ff + 32'd1;

   always_comb begin
      dx = 33'(req_data.pose_x) - 33'(last_x_ff);
      dy = 33'(req_data.pose_y) - 33'(last_y_ff);
      adx = dx[32] ? 33'(-dx) : 33'(dx);
      ady = dy[32] ? 33'(-dy) : 33'(dy);
      dh = req_data.pose_heading - last_h_ff;
      adh = dh[15] ? (17'h10000 - {1'b0, dh}) : {1'b0, dh};
   end

   assign near_pos = !far_ff && (({1'b0, sq_x_ff} + {1'b0, sq_y_ff}) < {1'b0, thr_sq_ff});
   assign gate_accept = !have_kf_ff || !(near_pos && near_rot_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kgst_pkg::FR_IDLE: begin
            if (accept && req_data.first_of_scan) begin
               state_in = kgst_pkg::FR_SQUARE;
            end
         end
         kgst_pkg::FR_SQUARE: state_in = kgst_pkg::FR_DECIDE;
         kgst_pkg::FR_DECIDE: state_in = kgst_pkg::FR_IDLE;
         default: state_in = kgst_pkg::FR_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      push = 1'b0;
      push_entry.local_x = req_data.local_x;
      push_entry.local_y = req_data.local_y;
      push_entry.pose_x = last_x_ff;
      push_entry.pose_y = last_y_ff;
      push_entry.heading = last_h_ff;
      push_entry.keyframe_count = kf_count_ff;
      case (state_ff)
         kgst_pkg::FR_IDLE: begin
            req_stall = queue_full;
            push = accept && !req_data.first_of_scan && scan_acc_ff && !req_data.pose_only;
         end
         kgst_pkg::FR_DECIDE: begin
            push = gate_accept && !pend_pose_only_ff;
            push_entry.local_x = pend_lx_ff;
            push_entry.local_y = pend_ly_ff;
            push_entry.pose_x = pend_x_ff;
            push_entry.pose_y = pend_y_ff;
            push_entry.heading = pend_h_ff;
            push_entry.keyframe_count = kf_next;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kgst_pkg::FR_IDLE;
         trans_thr_ff <= '0;
         rot_thr_ff <= '0;
         have_kf_ff <= 1'b0;
         scan_acc_ff <= 1'b0;
         last_x_ff <= '0;
         last_y_ff <= '0;
         last_h_ff <= '0;
         kf_count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               kgst_pkg::CSR_TRANSLATION: trans_thr_ff <= csr_wdata;
               kgst_pkg::CSR_ROTATION: rot_thr_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (state_ff == kgst_pkg::FR_DECIDE) begin
            scan_acc_ff <= gate_accept;
            if (gate_accept) begin
               have_kf_ff <= 1'b1;
               last_x_ff <= pend_x_ff;
               last_y_ff <= pend_y_ff;
               last_h_ff <= pend_h_ff;
               kf_count_ff <= kf_next;
            end
         end
      end
   end

   // gate datapath: differences on accept, squares next, compare on decide
   always_ff @(posedge clock) begin
      if (state_ff == kgst_pkg::FR_IDLE && accept && req_data.first_of_scan) begin
         pend_x_ff <= req_data.pose_x;
         pend_y_ff <= req_data.pose_y;
         pend_h_ff <= req_data.pose_heading;
         pend_lx_ff <= req_data.local_x;
         pend_ly_ff <= req_data.local_y;
         pend_pose_only_ff <= req_data.pose_only;
         adx_ff <= adx[30:0];
         ady_ff <= ady[30:0];
         far_ff <= adx[32] || adx[31] || ady[32] || ady[31];
         near_rot_ff <= (adh < {1'b0, rot_thr_ff});
      end
      if (state_ff == kgst_pkg::FR_SQUARE) begin
         sq_x_ff <= adx_ff * adx_ff;
         sq_y_ff <= ady_ff * ady_ff;
         thr_sq_ff <= trans_thr_ff * trans_thr_ff;
      end
   end

endmodule

[rtl/core/kgst_back.sv]
`timescale 1ns / 1ps

module kgst_back #(
   parameter int FRACTION_BITS = 16,
   parameter int TRIG_TABLE_DEPTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  kgst_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output kgst_pkg::rsp_type   rsp_data
);

   localparam int IDX_W = $clog2(TRIG_TABLE_DEPTH);
   localparam int TRIG_W = FRACTION_BITS + 2;
   localparam int PW = FRACTION_BITS + 34;
   localparam int SW = PW + 1;
   localparam int RW = SW - FRACTION_BITS;
   localparam logic signed [SW-1:0] HALF_LSB = {{(SW-1){1'b0}}, 1'b1} << (FRACTION_BITS - 1);

   typedef logic signed [TRIG_W-1:0] trig_rom_type [TRIG_TABLE_DEPTH];

   function automatic trig_rom_type build_rom(input logic want_cos);
      trig_rom_type rom;
      logic [63:0] p;
      logic [31:0] ph;
      for (int k = 0; k < TRIG_TABLE_DEPTH; k++) begin
         p = (64'(k) << 32) / 64'(TRIG_TABLE_DEPTH);
         ph = p[31:0] + (want_cos ? 32'h4000_0000 : 32'h0000_0000);
         rom[k] = TRIG_W'(kgst_pkg::phase_sine(ph, FRACTION_BITS));
      end
      return rom;
   endfunction

   localparam trig_rom_type SIN_ROM = build_rom(1'b0);
   localparam trig_rom_type COS_ROM = build_rom(1'b1);

   logic en;

   logic [31:0] k_sum;
   logic [15:0] k_wide;
   logic [15:0] k_wrap;

   logic               st1_valid_ff;
   logic [IDX_W-1:0]   st1_idx_ff;
   logic signed [31:0] st1_lx_ff, st1_ly_ff, st1_px_ff, st1_py_ff;
   logic [31:0]        st1_kf_ff;

   logic                    st2_valid_ff;
   logic signed [TRIG_W-1:0] st2_sin_ff, st2_cos_ff;
   logic signed [31:0]      st2_lx_ff, st2_ly_ff, st2_px_ff, st2_py_ff;
   logic [31:0]             st2_kf_ff;

   logic signed [PW-1:0] sin_ext, cos_ext, lx_ext, ly_ext;
   logic                 st3_valid_ff;
   logic signed [PW-1:0] st3_cx_ff, st3_sy_ff, st3_sx_ff, st3_cy_ff;
   logic signed [31:0]   st3_px_ff, st3_py_ff;
   logic [31:0]          st3_kf_ff;

   logic signed [SW-1:0] sum_x, sum_y;
   logic                 st4_valid_ff;
   logic signed [RW-1:0] st4_rx_ff, st4_ry_ff;
   logic signed [31:0]   st4_px_ff, st4_py_ff;
   logic [31:0]          st4_kf_ff;

   logic               st5_valid_ff;
   logic signed [31:0] st5_wx_ff, st5_wy_ff;
   logic [31:0]        st5_kf_ff;

   logic signed [31:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic signed [31:0] min_x_in, min_y_in, max_x_in, max_y_in;
   logic [31:0]        points_ff, points_in;
   logic               rsp_valid_ff;
   kgst_pkg::rsp_type  rsp_data_ff;

   // whole pipe advances together while the output register can move
   assign en = !rsp_valid_ff || !rsp_stall;
   assign pop = en && !queue_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      k_sum = (32'(head_entry.heading) * 32'(TRIG_TABLE_DEPTH)) + 32'd32768;
      k_wide = k_sum[31:16];
      k_wrap = (k_wide >= 16'(TRIG_TABLE_DEPTH)) ? k_wide - 16'(TRIG_TABLE_DEPTH) : k_wide;
   end

   always_comb begin
      sin_ext = PW'(st2_sin_ff);
      cos_ext = PW'(st2_cos_ff);
      lx_ext = PW'(st2_lx_ff);
      ly_ext = PW'(st2_ly_ff);
      sum_x = SW'(st3_cx_ff) - SW'(st3_sy_ff) + HALF_LSB;
      sum_y = SW'(st3_sx_ff) + SW'(st3_cy_ff) + HALF_LSB;
   end

   always_comb begin
      min_x_in = (st5_wx_ff < min_x_ff) ? st5_wx_ff : min_x_ff;
      min_y_in = (st5_wy_ff < min_y_ff) ? st5_wy_ff : min_y_ff;
      max_x_in = (st5_wx_ff > max_x_ff) ? st5_wx_ff : max_x_ff;
      max_y_in = (st5_wy_ff > max_y_ff) ? st5_wy_ff : max_y_ff;
      points_in = (points_ff == 32'hFFFF_FFFF) ? points_ff : points_ff + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
         st4_valid_ff <= 1'b0;
         st5_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_x_ff <= 32'h7FFF_FFFF;
         min_y_ff <= 32'h7FFF_FFFF;
         max_x_ff <= 32'h8000_0000;
         max_y_ff <= 32'h8000_0000;
         points_ff <= '0;
      end else if (en) begin
         st1_valid_ff <= !queue_empty;
         st2_valid_ff <= st1_valid_ff;
         st3_valid_ff <= st2_valid_ff;
         st4_valid_ff <= st3_valid_ff;
         st5_valid_ff <= st4_valid_ff;
         rsp_valid_ff <= st5_valid_ff;
         if (st5_valid_ff) begin
            min_x_ff <= min_x_in;
            min_y_ff <= min_y_in;
            max_x_ff <= max_x_in;
            max_y_ff <= max_y_in;
            points_ff <= points_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st1_idx_ff <= k_wrap[IDX_W-1:0];
         st1_lx_ff <= head_entry.local_x;
         st1_ly_ff <= head_entry.local_y;
         st1_px_ff <= head_entry.pose_x;
         st1_py_ff <= head_entry.pose_y;
         st1_kf_ff <= head_entry.keyframe_count;

         st2_sin_ff <= SIN_ROM[st1_idx_ff];
         st2_cos_ff <= COS_ROM[st1_idx_ff];
         st2_lx_ff <= st1_lx_ff;
         st2_ly_ff <= st1_ly_ff;
         st2_px_ff <= st1_px_ff;
         st2_py_ff <= st1_py_ff;
         st2_kf_ff <= st1_kf_ff;

         st3_cx_ff <= cos_ext * lx_ext;
         st3_sy_ff <= sin_ext * ly_ext;
         st3_sx_ff <= sin_ext * lx_ext;
         st3_cy_ff <= cos_ext * ly_ext;
         st3_px_ff <= st2_px_ff;
         st3_py_ff <= st2_py_ff;
         st3_kf_ff <= st2_kf_ff;

         st4_rx_ff <= RW'(sum_x >>> FRACTION_BITS);
         st4_ry_ff <= RW'(sum_y >>> FRACTION_BITS);
         st4_px_ff <= st3_px_ff;
         st4_py_ff <= st3_py_ff;
         st4_kf_ff <= st3_kf_ff;

         st5_wx_ff <= kgst_pkg::sat32(36'(st4_rx_ff) + 36'(st4_px_ff));
         st5_wy_ff <= kgst_pkg::sat32(36'(st4_ry_ff) + 36'(st4_py_ff));
         st5_kf_ff <= st4_kf_ff;

         rsp_data_ff.world_x <= st5_wx_ff;
         rsp_data_ff.world_y <= st5_wy_ff;
         rsp_data_ff.box_min_x <= min_x_in;
         rsp_data_ff.box_min_y <= min_y_in;
         rsp_data_ff.box_max_x <= max_x_in;
         rsp_data_ff.box_max_y <= max_y_in;
         rsp_data_ff.point_number <= points_in;
         rsp_data_ff.keyframe_number <= st5_kf_ff;
      end
   end

endmodule

[rtl/core/keyframe_gated_scan_transform.sv]
`timescale 1ns / 1ps

// Places laser scan points in the map frame, dropping scans whose pose is too close to the
// last keyframe. Points of a scan stream at one per cycle while the queue has room; the
// first request of a scan stalls the request side while the keyframe gate squares the pose
// offsets and then compares them with the squared threshold. A four entry queue sits between
// the gate and the transform pipeline, so the request side keeps taking points, until the
// queue is full, while a result waits on rsp_stall. After a point leaves the queue, its result
// is registered in turn through the table index, sine/cosine table read, products, rounding,
// saturation and bounding box stages, all of which hold while rsp_stall holds the output. The
// user is to write thresholds through the csr port only while the block is idle; the block
// itself does not enforce this.
module keyframe_gated_scan_transform #(
   parameter int FRACTION_BITS = 16,
   parameter int TRIG_TABLE_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kgst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kgst_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [30:0]       csr_wdata
);

   logic                queue_full;
   logic                queue_empty;
   logic                push;
   logic                pop;
   kgst_pkg::entry_type push_entry;
   kgst_pkg::entry_type head_entry;

   kgst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   kgst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   kgst_back #(
      .FRACTION_BITS    (FRACTION_BITS),
      .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
